// ----- hw/rtl/uvs_pkg.sv -----
// ----------------------------------------------------------------------------
// uvs_pkg
// Shared types and constants for the unique value stack.
// ----------------------------------------------------------------------------
`default_nettype none

package uvs_pkg;

  localparam int unsigned DEPTH_DEF   = 64;
  localparam int unsigned VAL_W       = 32;
  localparam int unsigned FILL_W      = 7;
  localparam int unsigned CAP_W       = 7;
  localparam logic [6:0]  CAP_RESET   = 7'd64;

  typedef enum logic [1:0] {
    MODE_PUSH = 2'd0,
    MODE_POP  = 2'd1,
    MODE_DUMP = 2'd2,
    MODE_NONE = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_OVERFLOW  = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_UNDERFLOW = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DUMP,
    S_RESP
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;      // latch the incoming item
    logic scan_start;  // read entry 0
    logic scan_step;   // compare current entry, read next one up
    logic dump_start;  // read top entry
    logic dump_step;   // emit current entry, read next one down
    logic resp;        // emit the single result, update the stack
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic cnt_zero;
    logic at_cap;
    logic match;
    logic scan_done;
    logic dump_done;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/uvs_ctrl.sv -----
// ----------------------------------------------------------------------------
// uvs_ctrl
// Sequencer for push scan, dump walk and single-result operations.
// ----------------------------------------------------------------------------
`default_nettype none

module uvs_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic [1:0]      in_mode,
  input  wire uvs_pkg::stat_t  stat,
  output logic                 in_ready,
  output uvs_pkg::cmd_t        cmd
);

  uvs_pkg::state_t state_r, state_nxt;
  uvs_pkg::mode_t  mode;

  assign mode = uvs_pkg::mode_t'(in_mode);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= uvs_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      uvs_pkg::S_IDLE: begin
        if (in_valid) begin
          case (mode)
            uvs_pkg::MODE_PUSH: begin
              state_nxt = (stat.cnt_zero || stat.at_cap) ? uvs_pkg::S_RESP : uvs_pkg::S_SCAN;
            end
            uvs_pkg::MODE_POP:  state_nxt = uvs_pkg::S_RESP;
            uvs_pkg::MODE_DUMP: begin
              state_nxt = stat.cnt_zero ? uvs_pkg::S_RESP : uvs_pkg::S_DUMP;
            end
            default:            state_nxt = uvs_pkg::S_IDLE;
          endcase
        end
      end
      uvs_pkg::S_SCAN: begin
        if (stat.match || stat.scan_done) state_nxt = uvs_pkg::S_RESP;
      end
      uvs_pkg::S_DUMP: begin
        if (stat.out_free && stat.dump_done) state_nxt = uvs_pkg::S_IDLE;
      end
      uvs_pkg::S_RESP: begin
        if (stat.out_free) state_nxt = uvs_pkg::S_IDLE;
      end
      default: state_nxt = uvs_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state_r)
      uvs_pkg::S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        cmd.scan_start = in_valid && (mode == uvs_pkg::MODE_PUSH) &&
                         !stat.cnt_zero && !stat.at_cap;
        cmd.dump_start = in_valid && (mode == uvs_pkg::MODE_DUMP) && !stat.cnt_zero;
      end
      uvs_pkg::S_SCAN: cmd.scan_step = 1'b1;
      uvs_pkg::S_DUMP: cmd.dump_step = stat.out_free;
      uvs_pkg::S_RESP: cmd.resp      = stat.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/uvs_dpath.sv -----
// ----------------------------------------------------------------------------
// uvs_dpath
// Entry memory, fill count, capacity register and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module uvs_dpath #(
  parameter int unsigned DEPTH = uvs_pkg::DEPTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire uvs_pkg::cmd_t               cmd,
  input  wire logic [1:0]                  in_mode,
  input  wire logic [uvs_pkg::VAL_W-1:0]   in_value,
  input  wire logic                        cap_we,
  input  wire logic [uvs_pkg::CAP_W-1:0]   cap_wdata,
  output logic      [uvs_pkg::CAP_W-1:0]   cap_val,
  output uvs_pkg::stat_t                   stat,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic      [2:0]                  out_status,
  output logic      [uvs_pkg::VAL_W-1:0]   out_entry,
  output logic      [uvs_pkg::FILL_W-1:0]  out_fill,
  output logic                             out_last
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [uvs_pkg::CAP_W-1:0] DEPTH_C = uvs_pkg::CAP_W'(DEPTH);

  logic [uvs_pkg::VAL_W-1:0] mem [DEPTH];

  logic [CW-1:0]              count_r, count_nxt;
  logic [uvs_pkg::CAP_W-1:0]  cap_r;
  logic [uvs_pkg::VAL_W-1:0]  value_r;
  uvs_pkg::mode_t             op_r;
  logic [AW-1:0]              ptr_r, ptr_nxt;
  logic                       dup_r;
  logic [uvs_pkg::VAL_W-1:0]  rdata_r;

  logic                       out_valid_r;
  logic [2:0]                 status_r, status_nxt;
  logic [uvs_pkg::VAL_W-1:0]  entry_r, entry_nxt;
  logic [uvs_pkg::FILL_W-1:0] fill_r, fill_nxt;
  logic                       last_r, last_nxt;

  logic [uvs_pkg::CAP_W-1:0]  eff_cap;
  logic                       rd_en;
  logic [AW-1:0]              rd_addr;
  logic                       wr_en;
  logic                       load;
  logic                       out_free;

  assign eff_cap  = (cap_r > DEPTH_C) ? DEPTH_C : cap_r;
  assign out_free = !out_valid_r || out_ready;

  assign stat.cnt_zero  = (count_r == '0);
  assign stat.at_cap    = (uvs_pkg::CAP_W'(count_r) >= eff_cap);
  assign stat.match     = (rdata_r == value_r);
  assign stat.scan_done = ((CW'(ptr_r) + CW'(1)) == count_r);
  assign stat.dump_done = (ptr_r == '0);
  assign stat.out_free  = out_free;

  // read port: one entry ahead of the walk so each cycle sees fresh data
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    ptr_nxt = ptr_r;
    if (cmd.scan_start) begin
      rd_en   = 1'b1;
      rd_addr = '0;
      ptr_nxt = '0;
    end else if (cmd.dump_start) begin
      rd_en   = 1'b1;
      rd_addr = AW'(count_r - CW'(1));
      ptr_nxt = rd_addr;
    end else if (cmd.scan_step) begin
      rd_en   = !stat.scan_done;
      rd_addr = ptr_r + AW'(1);
      ptr_nxt = rd_addr;
    end else if (cmd.dump_step) begin
      rd_en   = !stat.dump_done;
      rd_addr = ptr_r - AW'(1);
      ptr_nxt = rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) rdata_r <= mem[rd_addr];
    if (wr_en) mem[AW'(count_r)] <= value_r;
  end

  // result formation
  always_comb begin
    load       = 1'b0;
    wr_en      = 1'b0;
    count_nxt  = count_r;
    status_nxt = uvs_pkg::ST_OK;
    entry_nxt  = '0;
    fill_nxt   = uvs_pkg::FILL_W'(count_r);
    last_nxt   = 1'b1;
    if (cmd.dump_step) begin
      load      = 1'b1;
      entry_nxt = rdata_r;
      last_nxt  = stat.dump_done;
    end else if (cmd.resp) begin
      load = 1'b1;
      case (op_r)
        uvs_pkg::MODE_PUSH: begin
          if (stat.at_cap) begin
            status_nxt = uvs_pkg::ST_OVERFLOW;
          end else if (dup_r) begin
            status_nxt = uvs_pkg::ST_DUPLICATE;
          end else begin
            wr_en     = 1'b1;
            count_nxt = count_r + CW'(1);
          end
        end
        uvs_pkg::MODE_POP: begin
          if (stat.cnt_zero) begin
            status_nxt = uvs_pkg::ST_UNDERFLOW;
          end else begin
            count_nxt = count_r - CW'(1);
          end
        end
        default: status_nxt = uvs_pkg::ST_EMPTY;
      endcase
      fill_nxt = uvs_pkg::FILL_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cap_r       <= uvs_pkg::CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cap_we) cap_r <= cap_wdata;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    if (cmd.accept) begin
      value_r <= in_value;
      op_r    <= uvs_pkg::mode_t'(in_mode);
      dup_r   <= 1'b0;
    end else if (cmd.scan_step && stat.match) begin
      dup_r <= 1'b1;
    end
    if (load) begin
      status_r <= status_nxt;
      entry_r  <= entry_nxt;
      fill_r   <= fill_nxt;
      last_r   <= last_nxt;
    end
  end

  assign cap_val    = cap_r;
  assign out_valid  = out_valid_r;
  assign out_status = status_r;
  assign out_entry  = entry_r;
  assign out_fill   = fill_r;
  assign out_last   = last_r;

endmodule

`default_nettype wire

// ----- hw/rtl/unique_value_stack.sv -----
// ----------------------------------------------------------------------------
// unique_value_stack
// Bounded LIFO of signed 32-bit values that rejects duplicates.
// ----------------------------------------------------------------------------
// Usage: operations arrive on the in_ stream (in_tuser = mode: push, pop,
// dump; in_tdata = value to push). Results leave on the out_ stream with a
// status in out_tuser and entry value plus fill level in out_tdata; out_tlast
// marks the final result of an operation. A dump of n entries gives n
// transfers from top to bottom, an empty dump gives one transfer.
// A pop, a push to a full or empty stack, or an empty dump enters S_RESP
// after the transfer; its result is registered there once the output
// register is free. A push to a stack of n entries walks the single memory
// read port, 1 entry per cycle, stopping at the first match. A dump reads
// the top entry on the transfer, then streams 1 entry per cycle while the
// output register is free. One operation is in flight at a time; the next
// is taken once the previous one's last result is in the output register.
// Reset empties the stack and sets the capacity register to 64; memory
// contents are not cleared. A stalled receiver holds the output register
// and pauses the dump walk or the final update; nothing is dropped.
// The user writes capacity (APB, address 0) only while idle; not enforced.
// ----------------------------------------------------------------------------
`default_nettype none

module unique_value_stack #(
  parameter int unsigned DEPTH = uvs_pkg::DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] data_value
  input  wire logic [1:0]  in_tuser,   // [1:0] mode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // [31:0] entry_value, [38:32] fill_level, [39] zero
  output logic [2:0]       out_tuser,  // [2:0] status
  output logic             out_tlast,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  uvs_pkg::cmd_t  cmd;
  uvs_pkg::stat_t stat;

  logic                        cap_we;
  logic [uvs_pkg::CAP_W-1:0]   cap_val;
  logic [uvs_pkg::VAL_W-1:0]   entry;
  logic [uvs_pkg::FILL_W-1:0]  fill;

  assign cfg_pready = 1'b1;
  assign cap_we     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && !cfg_paddr[2];
  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : {{(32 - uvs_pkg::CAP_W){1'b0}}, cap_val};

  uvs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_mode  (in_tuser),
    .stat     (stat),
    .in_ready (in_tready),
    .cmd      (cmd)
  );

  uvs_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_mode    (in_tuser),
    .in_value   (in_tdata),
    .cap_we     (cap_we),
    .cap_wdata  (cfg_pwdata[uvs_pkg::CAP_W-1:0]),
    .cap_val    (cap_val),
    .stat       (stat),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (out_tuser),
    .out_entry  (entry),
    .out_fill   (fill),
    .out_last   (out_tlast)
  );

  assign out_tdata = {1'b0, fill, entry};

endmodule

`default_nettype wire
